// File: rtl/core/abs_pkg.sv
package abs_pkg;

    localparam int TIME_BITS = 32;
    localparam int CMP_BITS  = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int ADDR_BITS = 5;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [CMP_BITS-1:0]  cmp_t;

    typedef enum logic [2:0] {
        MODE_WAIT   = 3'd0,
        MODE_IDLE   = 3'd1,
        MODE_SETUP  = 3'd2,
        MODE_SHORT  = 3'd3,
        MODE_LONG   = 3'd4,
        MODE_CSETUP = 3'd5,
        MODE_CWAIT  = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        REG_RING_LEN        = 3'd0,
        REG_SHORT_INTERVAL  = 3'd1,
        REG_LONG_INTERVAL   = 3'd2,
        REG_COOLDOWN_PERIOD = 3'd3,
        REG_INIT_BELL_COUNT = 3'd4,
        REG_DEBOUNCE_PERIOD = 3'd5
    } reg_idx_t;

    localparam logic [15:0] RING_LEN_RST        = 16'd500;
    localparam logic [31:0] SHORT_INTERVAL_RST  = 32'd1000;
    localparam logic [31:0] LONG_INTERVAL_RST   = 32'd300000;
    localparam logic [31:0] COOLDOWN_PERIOD_RST = 32'd10000;
    localparam logic [7:0]  INIT_BELL_COUNT_RST = 8'd2;
    localparam logic [7:0]  DEBOUNCE_PERIOD_RST = 8'd10;

    localparam logic [7:0] PAT_MASK    = 8'b11000111;
    localparam logic [7:0] PAT_PRESS   = 8'b11000000;
    localparam logic [7:0] PAT_RELEASE = 8'b00000111;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        button_raw;
        logic        ready_raw;
        logic        signal_raw;
    } in_item_t;

    typedef struct packed {
        logic       bell_on;
        logic       alarm_led;
        logic       silent_led;
        logic       silent_now;
        logic [2:0] mode;
    } out_item_t;

endpackage

// File: rtl/core/alarm_bell_sequencer.sv
// alarm bell sequencer
// s_ channel: one item per polling pass, carrying the millisecond time and the
// raw active-low button, link ready and alarm pins. m_ channel: one result item
// per pass with bell, alarm LED, silent LED, silent mode and sequencer mode.
// An item is taken into an input register, worked through by compares and
// subtractions, and lands in the result register, which drives m_valid; one
// item is taken every cycle while the receiver does not stall.
// When the receiver stalls, the result register holds and the input register
// fills; s_ready drops only when both are full, so the block takes an item in
// the same cycle that the waiting result is taken.
// Configuration goes through the APB port, registers at byte addresses 0 to 20
// (bell duration, short interval, long interval, cooldown, initial bell count,
// debounce period); write them only while no item is in flight. Reads return
// the register value, pready is always high.
// aresetn (synchronous, active low) empties both registers, loads the default
// configuration and puts the sequencer into waiting for the link.
module alarm_bell_sequencer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  abs_pkg::in_item_t              s_item,
    output logic                           m_valid,
    input  logic                           m_ready,
    output abs_pkg::out_item_t             m_item,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [abs_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import abs_pkg::*;

    logic [15:0] ring_len_reg;
    logic [31:0] short_interval_reg;
    logic [31:0] long_interval_reg;
    logic [31:0] cooldown_period_reg;
    logic [7:0]  init_bell_count_reg;
    logic [7:0]  debounce_period_reg;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      advance;

    mode_t     mode_reg, mode_next;
    logic [7:0] bells_left_reg, bells_left_next;
    time_t     prev_ding_reg, prev_ding_next;
    time_t     cool_origin_reg, cool_origin_next;
    time_t     last_sample_reg, last_sample_next;
    logic [7:0] history_reg, history_next;
    logic      key_held_reg, key_held_next;
    logic      silent_reg, silent_next;
    logic      bell_reg, bell_next;
    logic      alarm_led_reg, alarm_led_next;

    reg_idx_t  reg_idx;
    logic      cfg_write;

    time_t     now;
    logic      ready_in, alarm_in;
    cmp_t      dt_bell, dt_sample, dt_cool;
    logic      bell_end, sample, press, release_hit;
    logic [7:0] shifted, masked, bells_dec;
    logic      ding_short, ding_long, ding;

    // configuration port
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[ADDR_BITS-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_len_reg        <= RING_LEN_RST;
            short_interval_reg  <= SHORT_INTERVAL_RST;
            long_interval_reg   <= LONG_INTERVAL_RST;
            cooldown_period_reg <= COOLDOWN_PERIOD_RST;
            init_bell_count_reg <= INIT_BELL_COUNT_RST;
            debounce_period_reg <= DEBOUNCE_PERIOD_RST;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_RING_LEN:        ring_len_reg        <= pwdata[15:0];
                REG_SHORT_INTERVAL:  short_interval_reg  <= pwdata;
                REG_LONG_INTERVAL:   long_interval_reg   <= pwdata;
                REG_COOLDOWN_PERIOD: cooldown_period_reg <= pwdata;
                REG_INIT_BELL_COUNT: init_bell_count_reg <= pwdata[7:0];
                REG_DEBOUNCE_PERIOD: debounce_period_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RING_LEN:        prdata = {16'd0, ring_len_reg};
            REG_SHORT_INTERVAL:  prdata = short_interval_reg;
            REG_LONG_INTERVAL:   prdata = long_interval_reg;
            REG_COOLDOWN_PERIOD: prdata = cooldown_period_reg;
            REG_INIT_BELL_COUNT: prdata = {24'd0, init_bell_count_reg};
            REG_DEBOUNCE_PERIOD: prdata = {24'd0, debounce_period_reg};
            default:             prdata = 32'd0;
        endcase
    end

    // item flow
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_item_reg.bell_on    <= bell_next;
            out_item_reg.alarm_led  <= alarm_led_next;
            out_item_reg.silent_led <= silent_reg;
            out_item_reg.silent_now <= silent_next;
            out_item_reg.mode       <= mode_next;
        end
    end

    // one pass
    assign now      = time_t'(in_item_reg.now_ms);
    assign ready_in = !in_item_reg.ready_raw;
    assign alarm_in = !in_item_reg.signal_raw;

    assign dt_bell   = cmp_t'(time_t'(now - prev_ding_reg));
    assign dt_sample = cmp_t'(time_t'(now - last_sample_reg));
    assign dt_cool   = cmp_t'(time_t'(now - cool_origin_reg));

    assign bell_end    = dt_bell >= cmp_t'(ring_len_reg);
    assign sample      = dt_sample > cmp_t'(debounce_period_reg);
    assign shifted     = {history_reg[6:0], in_item_reg.button_raw};
    assign masked      = shifted & PAT_MASK;
    assign press       = masked == PAT_PRESS;
    assign release_hit = key_held_reg && (masked == PAT_RELEASE);

    assign ding_short = (mode_reg == MODE_SHORT) && ready_in && alarm_in
                        && (dt_bell > cmp_t'(short_interval_reg));
    assign ding_long  = (mode_reg == MODE_LONG) && ready_in && alarm_in
                        && (dt_bell > cmp_t'(long_interval_reg));
    assign ding       = ding_short || ding_long;
    assign bells_dec  = bells_left_reg - 8'd1;

    // button debounce and silent toggle
    always_comb begin
        last_sample_next = last_sample_reg;
        history_next     = history_reg;
        key_held_next    = key_held_reg;
        silent_next      = silent_reg;
        if (sample) begin
            last_sample_next = now;
            history_next     = shifted;
            if (press) begin
                key_held_next = 1'b1;
            end else if (release_hit) begin
                key_held_next = 1'b0;
                silent_next   = !silent_reg;
            end
        end
    end

    // sequencer next state
    always_comb begin
        mode_next = mode_reg;
        unique case (mode_reg) inside
            MODE_IDLE: begin
                if (!ready_in) begin
                    mode_next = MODE_WAIT;
                end else if (alarm_in) begin
                    mode_next = MODE_SETUP;
                end
            end
            MODE_SETUP: mode_next = MODE_SHORT;
            MODE_SHORT, MODE_LONG: begin
                if (!ready_in) begin
                    mode_next = MODE_WAIT;
                end else if (!alarm_in) begin
                    mode_next = MODE_CSETUP;
                end else if (ding_short && bells_dec == 8'd0) begin
                    mode_next = MODE_LONG;
                end
            end
            MODE_CSETUP: mode_next = MODE_CWAIT;
            MODE_CWAIT: begin
                if (!ready_in) begin
                    mode_next = MODE_WAIT;
                end else if (dt_cool >= cmp_t'(cooldown_period_reg)) begin
                    mode_next = MODE_IDLE;
                end
            end
            default: mode_next = ready_in ? MODE_IDLE : MODE_WAIT;
        endcase
    end

    // sequencer outputs and timers
    always_comb begin
        alarm_led_next   = alarm_led_reg;
        bells_left_next  = bells_left_reg;
        cool_origin_next = cool_origin_reg;
        prev_ding_next   = prev_ding_reg;
        bell_next        = bell_reg && !bell_end;
        unique case (mode_reg) inside
            MODE_IDLE, MODE_CWAIT: ;
            MODE_SETUP: begin
                alarm_led_next  = 1'b1;
                bells_left_next = init_bell_count_reg;
            end
            MODE_SHORT, MODE_LONG: begin
                if (ready_in && !alarm_in) begin
                    alarm_led_next = 1'b0;
                end
                if (ding_short) begin
                    bells_left_next = bells_dec;
                end
                if (ding) begin
                    prev_ding_next = now;
                    if (!silent_next) begin
                        bell_next = 1'b1;
                    end
                end
            end
            MODE_CSETUP: cool_origin_next = now;
            default: alarm_led_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_WAIT;
            bells_left_reg  <= INIT_BELL_COUNT_RST;
            prev_ding_reg   <= '0;
            cool_origin_reg <= '0;
            last_sample_reg <= '0;
            history_reg     <= '0;
            key_held_reg    <= 1'b0;
            silent_reg      <= 1'b0;
            bell_reg        <= 1'b0;
            alarm_led_reg   <= 1'b0;
        end else if (advance) begin
            mode_reg        <= mode_next;
            bells_left_reg  <= bells_left_next;
            prev_ding_reg   <= prev_ding_next;
            cool_origin_reg <= cool_origin_next;
            last_sample_reg <= last_sample_next;
            history_reg     <= history_next;
            key_held_reg    <= key_held_next;
            silent_reg      <= silent_next;
            bell_reg        <= bell_next;
            alarm_led_reg   <= alarm_led_next;
        end
    end

    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg)
        else $error("input stalled with a free slot");

    a_setup_lights_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && mode_reg == MODE_SETUP |=> alarm_led_reg && mode_reg == MODE_SHORT)
        else $error("alarm setup did not enter short bells");

    a_silent_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_item_reg.silent_now == silent_reg && out_item_reg.mode == mode_reg)
        else $error("result item disagrees with state");

    a_silent_no_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !bell_reg && silent_next |=> !bell_reg)
        else $error("bell raised in silent mode");

endmodule

// File: verif/alarm_bell_sequencer_tb.sv
module alarm_bell_sequencer_tb;

    import abs_pkg::*;

    localparam int UNUSED_REG_IDX = 6;

    class panel_tracker;
        logic [15:0] ring_len;
        logic [31:0] short_interval;
        logic [31:0] long_interval;
        logic [31:0] cooldown_period;
        logic [7:0]  bell_count;
        logic [7:0]  debounce_period;

        mode_t       mode;
        logic [7:0]  bells_left;
        logic [31:0] prev_ding;
        logic [31:0] cool_origin;
        logic [31:0] last_sample;
        logic [7:0]  history;
        bit          key_held;
        bit          silent;
        bit          bell;
        bit          alarm_led;
        bit          silent_led;

        out_item_t   due_panels[$];
        int          errors;

        function new();
            ring_len        = RING_LEN_RST;
            short_interval  = SHORT_INTERVAL_RST;
            long_interval   = LONG_INTERVAL_RST;
            cooldown_period = COOLDOWN_PERIOD_RST;
            bell_count      = INIT_BELL_COUNT_RST;
            debounce_period = DEBOUNCE_PERIOD_RST;
            mode            = MODE_WAIT;
            bells_left      = 8'd2;
            prev_ding       = '0;
            cool_origin     = '0;
            last_sample     = '0;
            history         = '0;
            key_held        = 1'b0;
            silent          = 1'b0;
            bell            = 1'b0;
            alarm_led       = 1'b0;
            silent_led      = 1'b0;
            errors          = 0;
        endfunction

        function void write_reg(int idx, logic [31:0] value);
            case (idx)
                REG_RING_LEN:        ring_len        = value[15:0];
                REG_SHORT_INTERVAL:  short_interval  = value;
                REG_LONG_INTERVAL:   long_interval   = value;
                REG_COOLDOWN_PERIOD: cooldown_period = value;
                REG_INIT_BELL_COUNT: bell_count      = value[7:0];
                REG_DEBOUNCE_PERIOD: debounce_period = value[7:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] since(logic [31:0] now, logic [31:0] then_ms);
            return now - then_ms;
        endfunction

        function void ring(logic [31:0] now);
            prev_ding = now;
            if (!silent)
                bell = 1'b1;
        endfunction

        function void take_pass(in_item_t it);
            out_item_t   panel;
            logic [31:0] now;
            logic [7:0]  masked;
            bit          link_up;
            bit          alarm;
            now     = it.now_ms;
            link_up = !it.button_raw ? !it.ready_raw : !it.ready_raw;
            alarm   = !it.signal_raw;

            silent_led = silent;
            if (since(now, prev_ding) >= {16'd0, ring_len})
                bell = 1'b0;

            if (since(now, last_sample) > {24'd0, debounce_period}) begin
                last_sample = now;
                history     = {history[6:0], it.button_raw};
                masked      = history & PAT_MASK;
                if (masked == PAT_PRESS) begin
                    key_held = 1'b1;
                end else if (key_held && masked == PAT_RELEASE) begin
                    key_held = 1'b0;
                    silent   = !silent;
                end
            end

            case (mode) inside
                MODE_IDLE: begin
                    if (!link_up)
                        mode = MODE_WAIT;
                    else if (alarm)
                        mode = MODE_SETUP;
                end
                MODE_SETUP: begin
                    alarm_led  = 1'b1;
                    bells_left = bell_count;
                    mode       = MODE_SHORT;
                end
                MODE_SHORT, MODE_LONG: begin
                    if (!link_up) begin
                        mode = MODE_WAIT;
                    end else if (!alarm) begin
                        alarm_led = 1'b0;
                        mode      = MODE_CSETUP;
                    end else if (mode == MODE_SHORT) begin
                        if (since(now, prev_ding) > short_interval) begin
                            ring(now);
                            bells_left = bells_left - 8'd1;
                            if (bells_left == 8'd0)
                                mode = MODE_LONG;
                        end
                    end else if (since(now, prev_ding) > long_interval) begin
                        ring(now);
                    end
                end
                MODE_CSETUP: begin
                    cool_origin = now;
                    mode        = MODE_CWAIT;
                end
                MODE_CWAIT: begin
                    if (!link_up)
                        mode = MODE_WAIT;
                    else if (since(now, cool_origin) >= cooldown_period)
                        mode = MODE_IDLE;
                end
                default: begin
                    alarm_led = 1'b0;
                    mode      = link_up ? MODE_IDLE : MODE_WAIT;
                end
            endcase

            panel.bell_on    = bell;
            panel.alarm_led  = alarm_led;
            panel.silent_led = silent_led;
            panel.silent_now = silent;
            panel.mode       = mode;
            due_panels.push_back(panel);
        endfunction

        function void flag(string field, logic [2:0] want, logic [2:0] got);
            errors++;
            $error("%s: expected %0d, got %0d", field, want, got);
        endfunction

        function void match_panel(out_item_t got);
            out_item_t want;
            if (due_panels.size() == 0) begin
                errors++;
                $error("result item with nothing expected: %h", got);
                return;
            end
            want = due_panels.pop_front();
            if (got.bell_on !== want.bell_on)
                flag("bell_on", want.bell_on, got.bell_on);
            if (got.alarm_led !== want.alarm_led)
                flag("alarm_led", want.alarm_led, got.alarm_led);
            if (got.silent_led !== want.silent_led)
                flag("silent_led", want.silent_led, got.silent_led);
            if (got.silent_now !== want.silent_now)
                flag("silent_now", want.silent_now, got.silent_now);
            if (got.mode !== want.mode)
                flag("mode", want.mode, got.mode);
        endfunction
    endclass

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_item_t             s_item  = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_item_t            m_item;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [ADDR_BITS-1:0] paddr   = '0;
    logic [31:0]          pwdata  = '0;
    logic [31:0]          prdata;
    logic                 pready;

    panel_tracker book = new();

    bit          quiet = 1'b0;
    int          sink_stall = 0;
    logic [31:0] clock_ms = '0;
    bit          btn_level = 1'b1;
    int          btn_run = 0;
    bit          sig_level = 1'b1;
    int          sig_run = 0;
    int          link_run = 0;

    alarm_bell_sequencer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

    // result side with bursts of back-pressure
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                book.match_panel(m_item);
            if (sink_stall > 0) begin
                sink_stall--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                sink_stall = $urandom_range(0, 2);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(in_item_t it);
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!(s_valid && s_ready));
        book.take_pass(it);
    endtask

    task automatic hold_off(int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic pass_item(logic [31:0] now, bit btn, bit rdy, bit sig);
        in_item_t it;
        it.now_ms     = now;
        it.button_raw = btn;
        it.ready_raw  = rdy;
        it.signal_raw = sig;
        send_item(it);
    endtask

    task automatic settle(int extra);
        s_valid <= 1'b0;
        while (book.due_panels.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic cfg_write(int idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'(idx * 4);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        book.write_reg(idx, value);
    endtask

    task automatic set_config(logic [15:0] bd, logic [31:0] si, logic [31:0] li,
                              logic [31:0] cp, logic [7:0] cnt, logic [7:0] db);
        settle(4);
        cfg_write(REG_RING_LEN, {16'd0, bd});
        cfg_write(REG_SHORT_INTERVAL, si);
        cfg_write(REG_LONG_INTERVAL, li);
        cfg_write(REG_COOLDOWN_PERIOD, cp);
        cfg_write(REG_INIT_BELL_COUNT, {24'd0, cnt});
        cfg_write(REG_DEBOUNCE_PERIOD, {24'd0, db});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_phase(int items, int step_max, int alarm_run_max, bit flaky_link);
        in_item_t it;
        for (int n = 0; n < items; n++) begin
            if ($urandom_range(0, 63) == 0)
                clock_ms = $urandom();
            else
                clock_ms += $urandom_range(0, step_max);
            if (btn_run == 0) begin
                btn_level = !btn_level;
                btn_run   = $urandom_range(1, 8);
            end
            btn_run--;
            if (sig_run == 0) begin
                sig_level = !sig_level;
                sig_run   = $urandom_range(1, alarm_run_max);
            end
            sig_run--;
            if (link_run > 0)
                link_run--;
            else if (flaky_link && $urandom_range(0, 39) == 0)
                link_run = $urandom_range(1, 3);
            it.now_ms     = clock_ms;
            it.button_raw = btn_level;
            it.ready_raw  = (link_run > 0);
            it.signal_raw = sig_level;
            if (!quiet && $urandom_range(0, 5) == 0)
                hold_off($urandom_range(1, 3));
            send_item(it);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // link, alarm, short and long bells, cooldown with default settings
        pass_item(32'd0,      1, 1, 1);
        pass_item(32'd5,      1, 0, 1);
        pass_item(32'd20,     1, 0, 0);
        pass_item(32'd30,     1, 0, 0);
        pass_item(32'd1100,   1, 0, 0);
        pass_item(32'd1500,   1, 0, 0);
        pass_item(32'd1600,   1, 0, 0);
        pass_item(32'd2101,   1, 0, 0);
        pass_item(32'd302102, 1, 0, 0);
        pass_item(32'd302103, 1, 1, 0);
        pass_item(32'd302104, 1, 0, 0);
        pass_item(32'd302105, 1, 0, 0);
        pass_item(32'd302106, 1, 0, 0);
        pass_item(32'd302107, 1, 0, 1);
        pass_item(32'd302108, 1, 0, 1);
        pass_item(32'd312108, 1, 0, 1);
        // press then release toggles silent mode
        for (int k = 1; k <= 5; k++)
            pass_item(32'd312108 + 20 * k, 0, 0, 1);
        for (int k = 6; k <= 8; k++)
            pass_item(32'd312108 + 20 * k, 1, 0, 1);
        pass_item(32'hFFFF_FFFF, 1, 0, 1);

        set_config(16'd1, 32'd0, 32'd0, 32'd0, 8'd1, 8'd0);
        run_phase(250, 3, 30, 1'b1);

        set_config(16'd20, 32'd10, 32'd50, 32'd30, 8'd3, 8'd2);
        clock_ms = 32'hFFFF_FF00;
        run_phase(250, 8, 60, 1'b1);

        set_config(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 8'd255);
        cfg_write(UNUSED_REG_IDX, 32'h0000_0001);
        cfg_write(UNUSED_REG_IDX + 1, 32'hFFFF_FFFF);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        run_phase(150, 100000, 40, 1'b1);

        // zero bell count runs 256 short bells, zero duration ends each pulse at once
        set_config(16'd0, 32'd0, 32'd5, 32'd3, 8'd0, 8'd1);
        run_phase(400, 3, 600, 1'b0);

        set_config(16'($urandom_range(0, 60)), $urandom_range(0, 40),
                   $urandom_range(0, 200), $urandom_range(0, 100),
                   8'($urandom_range(0, 6)), 8'($urandom_range(0, 5)));
        run_phase(250, 10, 50, 1'b1);

        set_config(16'($urandom_range(1, 60)), $urandom_range(0, 40),
                   $urandom_range(0, 200), $urandom_range(0, 100),
                   8'($urandom_range(1, 6)), 8'($urandom_range(0, 5)));
        quiet = 1'b1;
        run_phase(250, 10, 50, 1'b1);

        settle(8);
        if (book.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
